// ===== rtl/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

  localparam int KEY_W     = 31;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int PROBE_W   = 5;
  localparam int SLOTS_DEF = 16;
  localparam int PROBE_MAX = 31;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lpht_if.sv =====
`default_nettype none

interface lpht_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [lpht_pkg::KEY_W-1:0]  key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface lpht_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::SLOT_W-1:0]   slot;
  logic [lpht_pkg::PROBE_W-1:0]  probe_count;

  modport source (output valid, output status, output slot, output probe_count, input ready);
  modport sink   (input valid, input status, input slot, input probe_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Hash table of SLOTS keys with open addressing and linear probing.
// in_chan carries one transaction per operation: action (insert or search)
// and a 31-bit key. out_chan returns exactly one transaction per operation:
// status, slot and probe_count.
// The home slot is key modulo SLOTS: a multiply by the reciprocal of SLOTS
// at acceptance gives the quotient, and the remainder follows in the next
// cycle. The probe then reads one slot of the key memory per cycle, back to
// back, with the first read issued with the remainder, up to SLOTS slots.
// When the probe ends the result is loaded into the output register, or
// into a holding register if that is still full; the next operation can
// be accepted in the cycle after the output register is loaded, and
// in_chan.ready is high only while no operation is in flight.
// After reset the block sweeps the memory, clearing one entry per cycle,
// and accepts nothing during that sweep.
// The output register holds a result until out_chan.ready; a new operation
// may be accepted meanwhile, and a finished result that finds the output
// register still full waits in a holding register until it drains.
`default_nettype none

module linear_probe_hash_table #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lpht_in_if.sink           in_chan,
  lpht_out_if.source        out_chan
);

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int DW = lpht_pkg::KEY_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_PROBE = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r;

  logic [DW-1:0] mem [SLOTS];
  logic [DW-1:0] rd_q;
  logic          wen;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;

  logic [AW-1:0]                   clr_r;
  logic [AW-1:0]                   cur_r;
  logic [AW-1:0]                   cur_next;
  logic [AW-1:0]                   cnt_r;
  logic                            act_r;
  logic [lpht_pkg::KEY_W-1:0]      key_r;

  logic                            mod_done;
  logic [AW-1:0]                   mod_rem;

  logic                            in_fire;
  logic                            out_free;
  logic                            out_load;
  logic                            last;
  logic                            rd_valid;
  logic                            rd_match;

  logic                            pr_done;
  lpht_pkg::status_t               pr_status;
  logic [AW-1:0]                   pr_slot;
  logic [PW-1:0]                   pr_probes;
  logic [lpht_pkg::PROBE_W-1:0]    pr_probes_sat;

  lpht_pkg::status_t               res_status_r;
  logic [lpht_pkg::SLOT_W-1:0]     res_slot_r;
  logic [lpht_pkg::PROBE_W-1:0]    res_probe_r;

  logic                            out_valid_r;
  lpht_pkg::status_t               out_status_r;
  logic [lpht_pkg::SLOT_W-1:0]     out_slot_r;
  logic [lpht_pkg::PROBE_W-1:0]    out_probe_r;

  assign in_chan.ready        = (state_r == S_IDLE);
  assign in_fire              = in_chan.valid && (state_r == S_IDLE);
  assign out_free             = !out_valid_r || out_chan.ready;
  assign out_load             = out_free && (((state_r == S_PROBE) && pr_done) ||
                                             (state_r == S_FIN));

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.probe_count = out_probe_r;

  lpht_mod #(.SLOTS(SLOTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .dividend (in_chan.key),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign cur_next = (cur_r == AW'(SLOTS - 1)) ? '0 : cur_r + AW'(1);
  assign raddr    = (state_r == S_MOD) ? mod_rem : cur_next;
  assign last     = (cnt_r == AW'(SLOTS - 1));
  assign rd_valid = rd_q[DW-1];
  assign rd_match = (rd_q[lpht_pkg::KEY_W-1:0] == key_r);

  always_comb begin
    pr_done   = 1'b0;
    pr_status = lpht_pkg::ST_MISSING;
    pr_slot   = '0;
    pr_probes = '0;
    wen       = 1'b0;
    waddr     = cur_r;
    wdata     = {1'b1, key_r};
    if (state_r == S_CLEAR) begin
      wen   = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == S_PROBE) begin
      if (act_r == lpht_pkg::ACT_INSERT) begin
        if (!rd_valid) begin
          pr_done   = 1'b1;
          pr_status = lpht_pkg::ST_INSERTED;
          pr_slot   = cur_r;
          wen       = 1'b1;
        end else if (last) begin
          pr_done   = 1'b1;
          pr_status = lpht_pkg::ST_FULL;
        end
      end else begin
        if (!rd_valid) begin
          pr_done   = 1'b1;
          pr_status = lpht_pkg::ST_MISSING;
          pr_probes = PW'(cnt_r);
        end else if (rd_match) begin
          pr_done   = 1'b1;
          pr_status = lpht_pkg::ST_FOUND;
          pr_slot   = cur_r;
          pr_probes = PW'(cnt_r) + PW'(1);
        end else if (last) begin
          pr_done   = 1'b1;
          pr_status = lpht_pkg::ST_MISSING;
          pr_probes = PW'(SLOTS);
        end
      end
    end
  end

  assign pr_probes_sat = (32'(pr_probes) > 32'(lpht_pkg::PROBE_MAX))
                         ? lpht_pkg::PROBE_W'(lpht_pkg::PROBE_MAX)
                         : lpht_pkg::PROBE_W'(pr_probes);

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (pr_done) begin
            if (out_free) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_chan.action;
      key_r <= in_chan.key;
    end
    if (state_r == S_MOD && mod_done) begin
      cur_r <= mod_rem;
      cnt_r <= '0;
    end else if (state_r == S_PROBE && !pr_done) begin
      cur_r <= cur_next;
      cnt_r <= cnt_r + AW'(1);
    end
    if (state_r == S_PROBE && pr_done) begin
      res_status_r <= pr_status;
      res_slot_r   <= lpht_pkg::SLOT_W'(pr_slot);
      res_probe_r  <= pr_probes_sat;
      if (out_free) begin
        out_status_r <= pr_status;
        out_slot_r   <= lpht_pkg::SLOT_W'(pr_slot);
        out_probe_r  <= pr_probes_sat;
      end
    end else if (state_r == S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_probe_r  <= res_probe_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpht_mod.sv =====
`default_nettype none

module lpht_mod #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] dividend,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   rem
);

  localparam int RW  = $clog2(SLOTS);
  localparam int KW  = lpht_pkg::KEY_W;
  localparam int MW  = KW + 1;
  localparam int PRW = KW + MW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (KW + RW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [MW-1:0] RECIP   = MW'(RECIP_FULL);
  localparam logic [KW-1:0] DIVISOR = KW'(SLOTS);

  logic [PRW-1:0] prod;
  logic [KW-1:0]  quo;
  logic [KW-1:0]  quo_r;
  logic [KW-1:0]  dvd_r;
  logic [KW-1:0]  back;
  logic           busy_r;

  assign prod = {{MW{1'b0}}, dividend} * {{KW{1'b0}}, RECIP};
  assign quo  = KW'(prod >> (KW + RW));
  assign back = quo_r * DIVISOR;
  assign done = busy_r;
  assign rem  = RW'(dvd_r - back);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      quo_r <= quo;
    end
  end

endmodule

`default_nettype wire
